### rtl/wsc_pkg.sv
// Package for the wavetable sound channel: opcodes, address map constants and helpers.
// No dependencies.
package wsc_pkg;
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	localparam logic [15:0] WAVE_LO  = 16'h4040;
	localparam logic [15:0] WAVE_HI  = 16'h407F;
	localparam logic [15:0] REG_LO   = 16'h4080;
	localparam logic [15:0] REG_HI   = 16'h408A;
	localparam logic [15:0] STAT_VOL = 16'h4090;
	localparam logic [15:0] STAT_MOD = 16'h4092;

	// Register file indexes.
	localparam logic [3:0] REG_VOL_ENV     = 4'd0;
	localparam logic [3:0] REG_FREQ_LO     = 4'd2;
	localparam logic [3:0] REG_FREQ_HI     = 4'd3;
	localparam logic [3:0] REG_MOD_ENV     = 4'd4;
	localparam logic [3:0] REG_TAB_PTR     = 4'd5;
	localparam logic [3:0] REG_MOD_FREQ_LO = 4'd6;
	localparam logic [3:0] REG_MOD_FREQ_HI = 4'd7;
	localparam logic [3:0] REG_MOD_TAB     = 4'd8;
	localparam logic [3:0] REG_WAVE_CTL    = 4'd9;
	localparam logic [3:0] REG_ENV_SPEED   = 4'd10;

	localparam int WAVE_DEPTH = 64;
	localparam int WAVE_AW    = 6;
	localparam int TAB_DEPTH  = 32;
	localparam int TAB_AW     = 5;

	typedef struct packed {
		logic [7:0]  read_data;
		logic [12:0] sample;
		logic        sample_valid;
	} result_t;
endpackage

### rtl/wsc_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module wsc_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

### rtl/wavetable_sound_channel_with_modulator.sv
// Top level of the wavetable sound channel with frequency modulator.
// Depends on wsc_pkg and wsc_ram.
//
// The channel takes one item at a time on s_axis and returns exactly one result item
// on m_axis per input item. A register access or register read passes through decode
// and output; a wave RAM read adds a state for the registered read. A tick that does
// not step the core reads wave RAM, multiplies, divides and outputs; one that steps
// the core first shifts and sums, and at slot zero first adds the modulation phase
// and reads the modulation table. These states come from the reads of the modulation
// table and wave RAM (each a registered RAM port) and from the shared adder, which
// performs the phase sum, the modulation phase add and the sample arithmetic in turn.
// After reset a clearing pass wipes the wave RAM and modulation table; no item is
// accepted then. s_axis_tready is low while an item is in work or its result waits.
module wavetable_sound_channel_with_modulator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: operation[1:0], address[17:2], write_data[25:18], open_bus[33:26], zeros
	input  logic [39:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tdata: read_data[7:0], sample[20:8], zeros
	output logic [23:0] m_axis_tdata,
	// tuser: sample_valid
	output logic        m_axis_tuser,
	input  logic        cfg_we,
	input  logic        cfg_wdata
);
	import wsc_pkg::*;

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_DEC   = 4'd2;
	localparam logic [3:0] ST_MPH   = 4'd3;
	localparam logic [3:0] ST_TABRD = 4'd4;
	localparam logic [3:0] ST_SHIFT = 4'd5;
	localparam logic [3:0] ST_SUM   = 4'd6;
	localparam logic [3:0] ST_WAVRD = 4'd7;
	localparam logic [3:0] ST_MUL   = 4'd8;
	localparam logic [3:0] ST_DIV   = 4'd9;
	localparam logic [3:0] ST_OUT   = 4'd10;
	localparam logic [3:0] ST_RDW   = 4'd11;

	logic [3:0]  state_q;
	logic        mute_q;
	logic [1:0]  op_q;
	logic [15:0] addr_q;
	logic [7:0]  wd_q, bus_q;
	logic [7:0]  rf_q [11];
	logic [5:0]  amp_q [2];
	logic [5:0]  div_q [2];
	logic [9:0]  etc_q;
	logic [18:0] cshift_q;
	logic [24:0] plat_q;
	logic [31:0] mph_q;
	logic [7:0]  mshift_q;
	logic [2:0]  slot_q;
	logic        tph_q;
	logic [6:0]  clr_q;
	logic [12:0] prod_q;
	result_t     res_q;
	logic        out_v_q;

	// Shared adder: operands chosen by the sequencer state.
	logic [31:0] add_a, add_b, add_y;
	always_comb begin
		add_a = 32'd0;
		add_b = 32'd0;
		unique case (state_q)
			ST_MPH: begin
				add_a = mph_q;
				add_b = {20'd0, rf_q[REG_MOD_FREQ_HI][3:0], rf_q[REG_MOD_FREQ_LO]};
			end
			ST_SUM: begin
				add_a = {7'd0, plat_q};
				add_b = {13'd0, cshift_q};
			end
			ST_OUT: begin
				add_a = {19'd0, prod_q};
				add_b = {20'd0, prod_q[12:1]};
			end
			default: begin
			end
		endcase
		add_y = add_a + add_b;
	end

	logic in_wave, in_reg;
	assign in_wave = (addr_q >= WAVE_LO) && (addr_q <= WAVE_HI);
	assign in_reg  = (addr_q >= REG_LO) && (addr_q <= REG_HI);
	logic [3:0] ridx;
	assign ridx = 4'(addr_q - REG_LO);

	// Memory ports.
	logic              wv_we, tb_we;
	logic [WAVE_AW-1:0] wv_addr;
	logic [TAB_AW-1:0]  tb_addr;
	logic [5:0]        wv_wd, wv_rd;
	logic [2:0]        tb_wd, tb_rd;
	always_comb begin
		wv_we = 1'b0;
		wv_addr = addr_q[WAVE_AW-1:0];
		wv_wd = wd_q[5:0];
		tb_we = 1'b0;
		tb_addr = mph_q[17:13];
		tb_wd = wd_q[2:0];
		if (state_q == ST_CLEAR) begin
			wv_we = 1'b1;
			wv_addr = clr_q[WAVE_AW-1:0];
			wv_wd = 6'd0;
			tb_we = 1'b1;
			tb_addr = clr_q[TAB_AW-1:0];
			tb_wd = 3'd0;
		end else if (state_q == ST_DEC && op_q == OP_WRITE) begin
			wv_we = in_wave && rf_q[REG_WAVE_CTL][7];
			tb_we = in_reg && ridx == REG_MOD_TAB;
			tb_addr = rf_q[REG_TAB_PTR][TAB_AW-1:0];
		end else if (state_q == ST_WAVRD) begin
			wv_addr = plat_q[24:19];
		end
	end

	wsc_ram #(.Width(6), .Depth(WAVE_DEPTH)) u_wave (
		.clk(clk), .we(wv_we), .addr(wv_addr), .wdata(wv_wd), .rdata(wv_rd)
	);
	wsc_ram #(.Width(3), .Depth(TAB_DEPTH)) u_tab (
		.clk(clk), .we(tb_we), .addr(tb_addr), .wdata(tb_wd), .rdata(tb_rd)
	);

	logic [5:0] depth_c, vol_c;
	assign depth_c = (amp_q[1] > 6'd32) ? 6'd32 : amp_q[1];
	assign vol_c   = (amp_q[0] > 6'd32) ? 6'd32 : amp_q[0];

	// The envelope tick counter reloads with speed times three once it would reach zero.
	// From zero it would first go negative, so the reload is one less, held at zero when
	// the speed is zero.
	logic [10:0] etc_reload;
	assign etc_reload = 11'(rf_q[REG_ENV_SPEED]) * 11'd3;
	logic [10:0] etc_next;
	assign etc_next = (etc_q == 10'd0) ?
			((rf_q[REG_ENV_SPEED] == 8'd0) ? 11'd0 : etc_reload - 11'd1) :
			((etc_q == 10'd1) ? etc_reload : 11'(etc_q) - 11'd1);
	logic env_clk;
	assign env_clk = (etc_q <= 10'd1);

	assign s_axis_tready = (state_q == ST_IDLE) && !out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			mute_q <= 1'b0;
			out_v_q <= 1'b0;
			for (int i = 0; i < 11; i++) rf_q[i] <= 8'd0;
			for (int i = 0; i < 2; i++) begin
				amp_q[i] <= 6'd0;
				div_q[i] <= 6'd0;
			end
			etc_q <= '0;
			cshift_q <= '0;
			plat_q <= '0;
			mph_q <= '0;
			mshift_q <= '0;
			slot_q <= '0;
			tph_q <= 1'b0;
		end else begin
			if (cfg_we) mute_q <= cfg_wdata;
			if (out_v_q && m_axis_tready) out_v_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 7'd1;
					if (clr_q == 7'(WAVE_DEPTH - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (s_axis_tvalid && s_axis_tready) begin
						op_q <= s_axis_tdata[1:0];
						addr_q <= s_axis_tdata[17:2];
						wd_q <= s_axis_tdata[25:18];
						bus_q <= s_axis_tdata[33:26];
						state_q <= ST_DEC;
					end
				end
				ST_DEC: begin
					res_q.read_data <= bus_q;
					res_q.sample <= '0;
					res_q.sample_valid <= 1'b0;
					state_q <= ST_OUT;
					if (op_q == OP_TICK && !rf_q[REG_WAVE_CTL][7] && !mute_q) begin
						tph_q <= !tph_q;
						state_q <= tph_q ? ST_WAVRD : (slot_q == 3'd0 ? ST_MPH : ST_SHIFT);
					end else if (op_q == OP_READ) begin
						if (in_wave) state_q <= ST_RDW;
						else if (addr_q == STAT_VOL)
							res_q.read_data <= {bus_q[7:6], amp_q[0]};
						else if (addr_q == STAT_MOD)
							res_q.read_data <= {bus_q[7:6], amp_q[1]};
					end else if (op_q == OP_WRITE && in_reg) begin
						if ((ridx == REG_VOL_ENV || ridx == REG_MOD_ENV) && wd_q[7])
							amp_q[ridx[2]] <= wd_q[5:0];
						if (ridx == REG_MOD_FREQ_HI || ridx == REG_MOD_TAB)
							mph_q <= '0;
						rf_q[ridx] <= wd_q;
						if (ridx == REG_MOD_FREQ_HI)
							rf_q[REG_TAB_PTR] <= 8'd0;
						else if (ridx == REG_MOD_TAB)
							rf_q[REG_TAB_PTR] <= {3'd0, 5'(rf_q[REG_TAB_PTR][4:0] + 5'd1)};
					end
				end
				ST_RDW: begin
					res_q.read_data <= {bus_q[7:6], wv_rd};
					state_q <= ST_OUT;
				end
				ST_MPH: begin
					cshift_q <= {7'd0, rf_q[REG_FREQ_HI][3:0], rf_q[REG_FREQ_LO]};
					mph_q <= add_y;
					state_q <= ST_TABRD;
				end
				ST_TABRD: begin
					state_q <= ST_SHIFT;
				end
				ST_SHIFT: begin
					if (slot_q == 3'd0) begin
						if (rf_q[REG_MOD_FREQ_HI][7]) mshift_q <= 8'h80;
						else mshift_q <= 8'h80 + 8'(({3'd0, depth_c} * {6'd0, tb_rd}) >> 1);
					end else begin
						cshift_q <= {cshift_q[17:0], 1'b0};
						mshift_q <= {1'b0, mshift_q[7:1]};
					end
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					if (mshift_q[0]) plat_q <= add_y[24:0];
					slot_q <= slot_q + 3'd1;
					etc_q <= etc_next[9:0];
					if (env_clk) begin
						for (int u = 0; u < 2; u++) begin
							if (!rf_q[u*4][7] && !rf_q[REG_FREQ_HI][6]) begin
								if (div_q[u] == 6'd0) begin
									if (rf_q[u*4][6]) begin
										if (amp_q[u] < 6'h3F) amp_q[u] <= amp_q[u] + 6'd1;
									end else if (amp_q[u] != 6'd0) begin
										amp_q[u] <= amp_q[u] - 6'd1;
									end
									div_q[u] <= rf_q[u*4][5:0];
								end else begin
									div_q[u] <= div_q[u] - 6'd1;
								end
							end
						end
					end
					state_q <= ST_WAVRD;
				end
				ST_WAVRD: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					prod_q <= 13'({wv_rd, 2'b00} * vol_c);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					unique case (rf_q[REG_WAVE_CTL][1:0])
						2'd0: prod_q <= prod_q >> 1;
						2'd1: prod_q <= 13'((26'(prod_q) * 26'd5462) >> 14);
						2'd2: prod_q <= prod_q >> 2;
						default: prod_q <= 13'((26'(prod_q) * 26'd6554) >> 15);
					endcase
					res_q.sample_valid <= 1'b1;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (res_q.sample_valid) res_q.sample <= add_y[12:0];
					out_v_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {3'd0, res_q.sample, res_q.read_data};
	assign m_axis_tuser  = res_q.sample_valid;

	// No item is taken while a result is still held.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !m_axis_tvalid) else $error("accept while result pending");
	// A produced sample never exceeds its range.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[20:8] <= 13'd6048))
		else $error("sample out of range");
	// Samples are zero when not valid.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[20:8] == 13'd0))
		else $error("stray sample");
endmodule

### tb/wsc_checker.sv
`timescale 1ns / 1ps
// Checker for the wavetable sound channel: watches both streams, predicts each result item
// from its own model of the channel state and compares. Depends on wsc_pkg.
module wsc_checker
	import wsc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [23:0] m_axis_tdata,
	input  logic        m_axis_tuser,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	output int          fail_count,
	output int          pending
);
	result_t     expected_q[$];
	logic        mute;
	logic [7:0]  regs[11];
	logic [5:0]  wave[64];
	logic [2:0]  modtab[32];
	logic [5:0]  amp[2];
	logic [5:0]  div[2];
	logic [9:0]  env_count;
	logic [18:0] car_shift;
	logic [24:0] psum, platch;
	logic [31:0] mphase;
	logic [7:0]  mshift;
	logic [2:0]  slot;
	logic        half;

	assign pending = expected_q.size();

	task automatic report(input string what, input int got, input int want);
		$display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	task automatic clock_env();
		logic [7:0] ctl;
		for (int u = 0; u < 2; u++) begin
			ctl = regs[u * 4];
			if (ctl[7] || regs[REG_FREQ_HI][6])
				continue;
			if (div[u] == 0) begin
				if (ctl[6]) begin
					if (amp[u] < 6'h3F)
						amp[u]++;
				end else if (amp[u] > 0) begin
					amp[u]--;
				end
				div[u] = ctl[5:0];
			end else begin
				div[u]--;
			end
		end
	endtask

	task automatic step_core();
		int t;
		int depth;
		if (slot == 0) begin
			car_shift = {7'd0, regs[REG_FREQ_HI][3:0], regs[REG_FREQ_LO]};
			mphase += {20'd0, regs[REG_MOD_FREQ_HI][3:0], regs[REG_MOD_FREQ_LO]};
			if (!regs[REG_MOD_FREQ_HI][7]) begin
				depth = (amp[1] > 6'h20) ? 32 : amp[1];
				mshift = 8'h80 + 8'(depth * modtab[mphase[17:13]] / 2);
			end else begin
				mshift = 8'h80;
			end
		end else begin
			car_shift = car_shift << 1;
			mshift = mshift >> 1;
		end
		psum = platch + 25'(car_shift);
		if (mshift[0])
			platch = psum;
		slot++;
		t = int'(env_count) - 1;
		if (t <= 0) begin
			t += regs[REG_ENV_SPEED] * 3;
			if (t < 0)
				t = 0;
			clock_env();
		end
		env_count = 10'(t);
	endtask

	task automatic write_reg(input int r, input logic [7:0] v);
		case (r)
			REG_VOL_ENV, REG_MOD_ENV: if (v[7]) amp[r / 4] = v[5:0];
			REG_MOD_FREQ_HI: begin
				mphase = 0;
				regs[REG_TAB_PTR] = 0;
			end
			REG_MOD_TAB: begin
				mphase = 0;
				modtab[regs[REG_TAB_PTR][4:0]] = v[2:0];
				regs[REG_TAB_PTR] = {3'd0, 5'(regs[REG_TAB_PTR] + 1)};
			end
			default: ;
		endcase
		regs[r] = v;
	endtask

	function automatic void reset_model();
		mute = 0;
		foreach (regs[i]) regs[i] = 0;
		foreach (wave[i]) wave[i] = 0;
		foreach (modtab[i]) modtab[i] = 0;
		amp = '{0, 0};
		div = '{0, 0};
		env_count = 0;
		car_shift = 0;
		psum = 0;
		platch = 0;
		mphase = 0;
		mshift = 0;
		slot = 0;
		half = 0;
	endfunction

	task automatic predict(input logic [39:0] d);
		logic [1:0]  op;
		logic [15:0] addr;
		logic [7:0]  wd, bus;
		result_t     r;
		int          k, s;
		op = d[1:0];
		addr = d[17:2];
		wd = d[25:18];
		bus = d[33:26];
		r.read_data = bus;
		r.sample = 0;
		r.sample_valid = 0;
		if (op == OP_TICK) begin
			if (!regs[REG_WAVE_CTL][7] && !mute) begin
				if (!half)
					step_core();
				half ^= 1;
				k = (amp[0] > 6'h20) ? 32 : amp[0];
				s = wave[platch[24:19]] * k * 4 / (regs[REG_WAVE_CTL][1:0] + 2);
				s += s >> 1;
				r.sample = 13'(s);
				r.sample_valid = 1;
			end
		end else if (op == OP_READ) begin
			if (addr >= WAVE_LO && addr <= WAVE_HI)
				r.read_data = {bus[7:6], wave[addr[5:0]]};
			else if (addr == STAT_VOL)
				r.read_data = {bus[7:6], amp[0]};
			else if (addr == STAT_MOD)
				r.read_data = {bus[7:6], amp[1]};
		end else if (op == OP_WRITE) begin
			if (addr >= WAVE_LO && addr <= WAVE_HI) begin
				if (regs[REG_WAVE_CTL][7])
					wave[addr[5:0]] = wd[5:0];
			end else if (addr >= REG_LO && addr <= REG_HI) begin
				write_reg(addr - REG_LO, wd);
			end
		end
		expected_q.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			reset_model();
			expected_q.delete();
			fail_count = 0;
		end else begin
			if (cfg_we)
				mute = cfg_wdata;
			if (s_axis_tvalid && s_axis_tready)
				predict(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_q.size() == 0) begin
					report("result item with none expected", m_axis_tdata, 0);
				end else begin
					want = expected_q.pop_front();
					if (m_axis_tdata[7:0] !== want.read_data)
						report("read_data", m_axis_tdata[7:0], want.read_data);
					if (m_axis_tdata[20:8] !== want.sample)
						report("sample", m_axis_tdata[20:8], want.sample);
					if (m_axis_tuser !== want.sample_valid)
						report("sample_valid", m_axis_tuser, want.sample_valid);
					if (m_axis_tdata[23:21] !== 3'd0)
						report("tdata padding", m_axis_tdata[23:21], 0);
				end
			end
		end
	end
endmodule

### tb/tb_wavetable_sound_channel_with_modulator.sv
`timescale 1ns / 1ps
// Top of the sound channel testbench: clock, reset, stimulus and verdict.
// Depends on wsc_pkg, the channel RTL and wsc_checker.
module tb_wavetable_sound_channel_with_modulator;
	import wsc_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        cfg_we = 0;
	logic        cfg_wdata = 0;
	int          fail_count;
	int          pending;
	int          idle_cycles = 0;
	bit          hold_off = 0;
	bit          sink_quiet = 0;

	always #5 clk = ~clk;

	wavetable_sound_channel_with_modulator i_dut (
		.clk, .arst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
		.m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
		.cfg_we, .cfg_wdata
	);

	wsc_checker i_checker (
		.clk, .arst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
		.m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
		.cfg_we, .cfg_wdata, .fail_count, .pending
	);

	// The watchdog counts cycles without any accepted item or result. The slowest paths are
	// a long receiver hold-off and the clearing pass after reset, well within its limit.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Receiver: a random stall before each result item, unless told to run flat out.
	// A long hold-off is requested by the stimulus and counted here in cycles.
	initial begin
		int gap;
		@(posedge clk iff arst_n);
		forever begin
			if (hold_off) begin
				m_axis_tready <= 0;
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
			gap = sink_quiet ? 0 : $urandom_range(0, 10);
			if (gap > 0) begin
				m_axis_tready <= 0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1;
			@(posedge clk iff m_axis_tvalid);
		end
	end

	bit quiet_src = 0;

	// One item offered and held until accepted, after a random gap unless the source runs quiet.
	task automatic send(input logic [1:0] op, input logic [15:0] addr,
			input logic [7:0] wd, input logic [7:0] bus);
		int gap;
		gap = quiet_src ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {6'd0, bus, wd, addr, op};
		@(posedge clk iff s_axis_tready);
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		@(posedge clk iff pending == 0);
		// Every item yields a result, but the block may still be finishing the last one.
		repeat (20) @(posedge clk);
	endtask

	task automatic set_mute(input logic v);
		drain();
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic wr(input int r, input logic [7:0] v);
		send(OP_WRITE, REG_LO + 16'(r), v, 8'($urandom));
	endtask

	// Loads a full waveform and modulation table so that ticks give varied samples.
	task automatic load_voice();
		wr(REG_WAVE_CTL, 8'h80 | 8'($urandom_range(0, 3)));
		for (int i = 0; i < 64; i++)
			send(OP_WRITE, WAVE_LO + 16'(i), 8'($urandom), 8'($urandom));
		wr(REG_WAVE_CTL, 8'($urandom_range(0, 3)));
		wr(REG_MOD_FREQ_HI, 8'($urandom) & 8'h8F);
		for (int i = 0; i < 32; i++)
			wr(REG_MOD_TAB, 8'($urandom));
		wr(REG_MOD_FREQ_HI, 8'($urandom_range(0, 1) ? 8'h80 : 8'h00) |
			8'($urandom_range(0, 15)));
		wr(REG_MOD_FREQ_LO, 8'($urandom));
		wr(REG_FREQ_LO, 8'($urandom));
		wr(REG_FREQ_HI, 8'($urandom_range(0, 1) ? 8'h40 : 8'h00) | 8'($urandom_range(0, 15)));
		wr(REG_VOL_ENV, 8'h80 | 8'($urandom_range(16, 63)));
		wr(REG_MOD_ENV, 8'h80 | 8'($urandom_range(0, 63)));
		wr(REG_VOL_ENV, 8'($urandom) & 8'h7F);
		wr(REG_MOD_ENV, 8'($urandom) & 8'h7F);
		wr(REG_ENV_SPEED, 8'($urandom_range(0, 1) ? 8'h00 : 8'($urandom)));
	endtask

	// A random item: mostly ticks, then reads, writes and some no-op items across the whole map.
	task automatic random_item();
		int     pick;
		logic [15:0] a;
		pick = $urandom_range(0, 99);
		case ($urandom_range(0, 5))
			0: a = 16'($urandom);
			1, 2: a = WAVE_LO + 16'($urandom_range(0, 63));
			3: a = REG_LO + 16'($urandom_range(0, 10));
			4: a = 16'h408B + 16'($urandom_range(0, 8));
			default: a = STAT_VOL + 16'($urandom_range(0, 2));
		endcase
		if (pick < 65)
			send(OP_TICK, 16'($urandom), 8'($urandom), 8'($urandom));
		else if (pick < 85)
			send(OP_READ, a, 8'($urandom), 8'($urandom));
		else if (pick < 97)
			send(OP_WRITE, a, 8'($urandom), 8'($urandom));
		else
			send(OP_NONE, a, 8'($urandom), 8'($urandom));
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1;

		// Directed part: field extremes, every operation and the corner cases.
		send(OP_TICK, 16'hFFFF, 8'hFF, 8'hFF);
		send(OP_READ, 16'h0000, 8'h00, 8'h00);
		send(OP_READ, WAVE_HI, 8'h00, 8'hFF);
		send(OP_WRITE, WAVE_LO, 8'hFF, 8'h00);       // ignored while wave RAM is locked
		wr(REG_WAVE_CTL, 8'h83);                     // wave RAM writable, ticks halted
		send(OP_WRITE, WAVE_LO, 8'hFF, 8'h00);
		send(OP_WRITE, WAVE_HI, 8'h2A, 8'h00);
		send(OP_TICK, 16'h0000, 8'h00, 8'h00);
		send(OP_READ, WAVE_LO, 8'h00, 8'hC0);
		send(OP_WRITE, 16'hFFFF, 8'hFF, 8'hFF);      // unmapped
		send(OP_NONE, STAT_VOL, 8'hFF, 8'h55);
		wr(REG_WAVE_CTL, 8'h00);
		wr(REG_VOL_ENV, 8'hFF);                      // volume loaded, above the cap
		wr(REG_MOD_ENV, 8'hBF);
		send(OP_READ, STAT_VOL, 8'h00, 8'hFF);
		send(OP_READ, 16'h4091, 8'h00, 8'hAA);
		send(OP_READ, STAT_MOD, 8'h00, 8'h3F);
		wr(REG_MOD_FREQ_HI, 8'h0F);
		wr(REG_MOD_TAB, 8'h07);
		wr(REG_FREQ_LO, 8'hFF);
		wr(REG_FREQ_HI, 8'h0F);
		wr(REG_ENV_SPEED, 8'h00);                    // envelope speed zero
		wr(REG_VOL_ENV, 8'h40);
		repeat (4) send(OP_TICK, 16'h0000, 8'h00, 8'h00);

		set_mute(1);
		repeat (3) send(OP_TICK, 16'h0000, 8'h00, 8'h00);
		set_mute(0);

		// Random part in phases; each starts from a freshly loaded voice.
		for (int ph = 0; ph < 6; ph++) begin
			quiet_src = (ph == 2);
			sink_quiet = (ph == 2);
			load_voice();
			if (ph == 3)
				hold_off = 1;      // receiver stalls while the sender keeps offering
			repeat (70) random_item();
			if (ph == 1)
				drain();           // sender pauses until every result is back
			repeat (20) send(OP_TICK, 16'd0, 8'($urandom), 8'($urandom));
			if (ph == 4) begin
				set_mute(1);
				repeat (20) random_item();
				set_mute(0);
			end
		end

		drain();
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
